// ===== hw/rtl/srsw_pkg.sv =====
// Shared types, codes and constants of the selective-repeat sender window.
package srsw_pkg;

	localparam int WINDOW_DEPTH_DEF = 32;
	localparam int MAX_PAYLOAD_DEF  = 1008;
	localparam int MAX_RESULTS      = 32;
	localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W        = 1;

	localparam logic [5:0]  WINDOW_LIMIT_RST = 6'd20;
	localparam logic [31:0] INIT_RTT_RST     = 32'd1000000;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTT  = 1'b1;

	localparam logic [1:0] CMD_SEG    = 2'd0;
	localparam logic [1:0] CMD_ACK    = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		K_SEND     = 4'd0,
		K_RESEND   = 4'd1,
		K_REFUSED  = 4'd2,
		K_ACK_OK   = 4'd3,
		K_CORRUPT  = 4'd4,
		K_OUTSIDE  = 4'd5,
		K_NONE_DUE = 4'd6,
		K_COMPLETE = 4'd7,
		K_END      = 4'd8
	} kind_t;

	// one window slot as held in the RAM
	typedef struct packed {
		logic        acked;
		logic [31:0] sent;
		logic [31:0] start;
		logic [9:0]  len;
	} ent_t;

	typedef struct packed {
		logic        start;
		logic [31:0] word;
	} crc_ctl_t;

	typedef struct packed {
		logic        done;
		logic [31:0] crc;
	} crc_stat_t;

	typedef struct packed {
		logic        start;
		logic [31:0] sample;
		logic        load;
		logic [31:0] init;
	} rtt_ctl_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rto;
	} rtt_stat_t;

endpackage

// ===== hw/rtl/srsw_ifs.sv =====
// Channel interfaces: request input, result output and configuration write.
interface srsw_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [9:0]         seg_length;
	logic signed [31:0] ack_num;
	logic [31:0]        ack_crc;
	logic [31:0]        now_us;
	modport source(output valid, cmd, seg_length, ack_num, ack_crc, now_us, input ready);
	modport sink(input valid, cmd, seg_length, ack_num, ack_crc, now_us, output ready);
endinterface

interface srsw_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [30:0] seq_num;
	logic [31:0] seg_offset;
	logic [9:0]  out_length;
	logic [4:0]  slot;
	logic [31:0] timeout_us;
	logic        last;
	modport source(output valid, kind, seq_num, seg_offset, out_length, slot, timeout_us,
		last, input ready);
	modport sink(input valid, kind, seq_num, seg_offset, out_length, slot, timeout_us,
		last, output ready);
endinterface

interface srsw_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [srsw_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/srsw_ram.sv =====
// Generic RAM, one write port and one registered read port.
module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/srsw_crc.sv =====
// CRC-32 of a big-endian word, one byte per cycle.
module srsw_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  srsw_pkg::crc_ctl_t  ctl,
	output srsw_pkg::crc_stat_t stat
);
	logic        busy_q, done_q;
	logic [1:0]  cnt_q;
	logic [31:0] c_q, w_q;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			x = (x >> 1) ^ (x[0] ? 32'hEDB88320 : 32'd0);
		end
		return x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			c_q <= 32'hFFFFFFFF;
			w_q <= ctl.word;
		end else if (busy_q) begin
			c_q <= crc_byte(c_q, w_q[31:24]);
			w_q <= {w_q[23:0], 8'd0};
		end
	end

	assign stat.done = done_q;
	assign stat.crc  = ~c_q;
endmodule

// ===== hw/rtl/srsw_rtt.sv =====
// Jacobson/Karels RTT estimator and retransmit timeout, four steps per sample.
module srsw_rtt (
	input  logic                clk,
	input  logic                arst_n,
	input  srsw_pkg::rtt_ctl_t  ctl,
	output srsw_pkg::rtt_stat_t stat
);
	typedef enum logic [4:0] {
		R_IDLE = 5'b00001,
		R_P1   = 5'b00010,
		R_P2   = 5'b00100,
		R_P3   = 5'b01000,
		R_P4   = 5'b10000
	} rst_t;

	rst_t        st_q;
	logic        done_q;
	logic [31:0] est_q, dev_q, rto_q, sample_q;
	logic        neg_s1, dneg_s2;
	logic [31:0] mag_s1, dmag_s2;

	logic [32:0] err, d;
	logic [33:0] t;

	assign err = {1'b0, sample_q} - {1'b0, est_q};
	assign d   = {1'b0, mag_s1} - {1'b0, dev_q};
	assign t   = {2'b00, est_q} + {dev_q, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= R_IDLE;
			done_q <= 1'b0;
			est_q  <= srsw_pkg::INIT_RTT_RST;
			dev_q  <= 32'd0;
			rto_q  <= srsw_pkg::INIT_RTT_RST;
		end else begin
			done_q <= 1'b0;
			if (ctl.load) begin
				est_q <= ctl.init;
				dev_q <= 32'd0;
				rto_q <= ctl.init;
			end
			case (st_q)
				R_IDLE: begin
					if (ctl.start) begin
						st_q <= R_P1;
					end
				end
				R_P1: st_q <= R_P2;
				R_P2: begin
					est_q <= neg_s1 ? est_q - (mag_s1 >> 3) : est_q + (mag_s1 >> 3);
					st_q  <= R_P3;
				end
				R_P3: begin
					dev_q <= dneg_s2 ? dev_q - (dmag_s2 >> 2) : dev_q + (dmag_s2 >> 2);
					st_q  <= R_P4;
				end
				R_P4: begin
					rto_q  <= (t[33:32] != 2'b00) ? 32'hFFFFFFFF : t[31:0];
					done_q <= 1'b1;
					st_q   <= R_IDLE;
				end
				default: st_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			sample_q <= ctl.sample;
		end
		if (st_q == R_P1) begin
			neg_s1 <= err[32];
			mag_s1 <= err[32] ? 32'(-err) : err[31:0];
		end
		if (st_q == R_P2) begin
			dneg_s2 <= d[32];
			dmag_s2 <= d[32] ? 32'(-d) : d[31:0];
		end
	end

	assign stat.done = done_q;
	assign stat.rto  = rto_q;
endmodule

// ===== hw/rtl/selective_repeat_sender_window_top.sv =====
// Selective-repeat sender window: slot RAM, ack CRC check, RTT estimator, control.
//
// Channels: req_in carries one request (new segment, received ack or timer tick),
// res_out returns its results, the final one with last set; cfg writes
// window_limit (index 0) and initial_rtt_us (index 1, also reloads the estimator).
// One request at a time. What each request takes, in order:
//   segment: a single result.
//   ack: the byte-serial CRC, then the CRC and window checks, which may turn
//        it away; otherwise a slot read, the 4-step RTT update and a read per
//        entry that the base slides over, until the window empties or an
//        unacked entry stops it; complete may follow when the window empties.
//   tick: a read per outstanding entry, since each slot is read through the
//        single read port of the slot RAM, at most WINDOW_DEPTH entries.
// Results pass through an output register, so req_in takes the next request
// while the last result still waits. A stall on res_out holds the block at its
// next result. Reset clears the window pointers and loads the estimator with
// 1000000 us; the slot RAM needs no clearing, only slots inside the window are read.
module selective_repeat_sender_window_top #(
	parameter int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF,
	parameter int MAX_PAYLOAD  = srsw_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srsw_cfg_if.sink   cfg,
	srsw_in_if.sink    req_in,
	srsw_out_if.source res_out
);
	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int RW     = $bits(srsw_pkg::ent_t);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_SEG      = 12'b000000000010,
		S_CRC      = 12'b000000000100,
		S_ACK_CHK  = 12'b000000001000,
		S_ACK_RD   = 12'b000000010000,
		S_ACK_RTT  = 12'b000000100000,
		S_SLIDE    = 12'b000001000000,
		S_SLIDE_RD = 12'b000010000000,
		S_ACK_OUT  = 12'b000100000000,
		S_ACK_CMP  = 12'b001000000000,
		S_TICK     = 12'b010000000000,
		S_TICK_RD  = 12'b100000000000
	} st_t;

	st_t st_q;

	logic [5:0]        window_limit_q;
	logic [30:0]       base_seq_q, next_seq_q;
	logic [31:0]       next_off_q;
	logic              end_seen_q;
	logic [SLOT_W-1:0] base_slot_q, next_slot_q, scan_slot_q, ack_slot_q;
	logic [9:0]        len_q;
	logic [31:0]       ack_q, acrc_q, now_q;
	logic              crc_bad_q;
	logic [31:0]       a_off_q;
	logic [9:0]        a_len_q;
	logic [CNT_W-1:0]  i_q;
	logic [srsw_pkg::RES_CNT_W-1:0] n_q;
	logic              pend_v_q;
	logic [30:0]       pend_seq_q;
	logic [31:0]       pend_off_q;
	logic [9:0]        pend_len_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic              ov_q, olast_q;
	logic [3:0]        okind_q;
	logic [30:0]       oseq_q;
	logic [31:0]       ooff_q, oto_q;
	logic [9:0]        olen_q;
	logic [SLOT_W-1:0] oslot_q;

	logic                   ram_we, ram_re;
	logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
	srsw_pkg::ent_t         ram_wdata, rd;
	logic [RW-1:0]          ram_rdata;

	srsw_pkg::crc_ctl_t  crc_c;
	srsw_pkg::crc_stat_t crc_s;
	srsw_pkg::rtt_ctl_t  rtt_c;
	srsw_pkg::rtt_stat_t rtt_s;

	logic              in_req, cfg_req, out_free, ld;
	srsw_pkg::kind_t   o_kind;
	logic [30:0]       o_seq;
	logic [31:0]       o_off;
	logic [9:0]        o_len, len_cut;
	logic [SLOT_W-1:0] o_slot;
	logic              o_last;

	logic [30:0]       outstanding, ack_dist;
	logic [6:0]        lim;
	logic              full, outside, tick_more, due, ack_cmp;
	logic [SLOT_W:0]   ack_sum;
	logic [SLOT_W-1:0] ack_slot, scan_nxt;
	logic [31:0]       age;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	assign rd = srsw_pkg::ent_t'(ram_rdata);

	assign in_req   = req_in.valid & req_in.ready;
	assign cfg_req  = cfg.valid & cfg.ready;
	assign out_free = !ov_q || res_out.ready;
	assign cfg.ready    = 1'b1;
	assign req_in.ready = (st_q == S_IDLE);

	assign len_cut = (int'(req_in.seg_length) > MAX_PAYLOAD) ? 10'(MAX_PAYLOAD)
		: req_in.seg_length;

	assign outstanding = next_seq_q - base_seq_q;
	always_comb begin
		if (window_limit_q == 6'd0) begin
			lim = 7'd1;
		end else if (int'(window_limit_q) > WINDOW_DEPTH) begin
			lim = 7'(WINDOW_DEPTH);
		end else begin
			lim = {1'b0, window_limit_q};
		end
	end
	assign full = outstanding >= 31'(lim);

	assign ack_dist = ack_q[30:0] - base_seq_q;
	assign outside  = ack_q[31] | (ack_dist >= outstanding);
	assign ack_sum  = {1'b0, base_slot_q} + ack_dist[SLOT_W:0];
	assign ack_slot = (ack_sum >= (SLOT_W+1)'(WINDOW_DEPTH))
		? SLOT_W'(ack_sum - (SLOT_W+1)'(WINDOW_DEPTH)) : ack_sum[SLOT_W-1:0];
	assign ack_cmp  = end_seen_q && (base_seq_q == next_seq_q);

	assign tick_more = (31'(i_q) < outstanding) && (n_q < srsw_pkg::RES_CNT_W'(srsw_pkg::MAX_RESULTS));
	assign age       = now_q - rd.sent;
	assign due       = !rd.acked && (age >= rtt_s.rto);
	assign scan_nxt  = slot_inc(scan_slot_q);

	assign crc_c.start = in_req && (req_in.cmd == srsw_pkg::CMD_ACK);
	assign crc_c.word  = req_in.ack_num;

	assign rtt_c.start  = (st_q == S_ACK_RD);
	assign rtt_c.sample = now_q - rd.sent;
	assign rtt_c.load   = cfg_req && (cfg.index == srsw_pkg::REG_INITIAL_RTT);
	assign rtt_c.init   = cfg.data;

	// RAM access and result selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = next_slot_q;
		ram_wdata = '{acked: 1'b0, sent: now_q, start: next_off_q, len: len_q};
		ram_re    = 1'b0;
		ram_raddr = base_slot_q;
		ld        = 1'b0;
		o_kind    = srsw_pkg::K_NONE_DUE;
		o_seq     = base_seq_q;
		o_off     = 32'd0;
		o_len     = 10'd0;
		o_slot    = '0;
		o_last    = 1'b1;
		case (st_q)
			S_SEG: begin
				ld    = out_free;
				o_seq = next_seq_q;
				o_off = next_off_q;
				if (end_seen_q || full) begin
					o_kind = srsw_pkg::K_REFUSED;
					o_len  = len_q;
				end else if (len_q == 10'd0) begin
					o_kind = (outstanding == 31'd0) ? srsw_pkg::K_COMPLETE : srsw_pkg::K_END;
				end else begin
					o_kind = srsw_pkg::K_SEND;
					o_len  = len_q;
					o_slot = next_slot_q;
					ram_we = out_free;
				end
			end
			S_ACK_CHK: begin
				o_seq = ack_q[30:0];
				if (crc_bad_q) begin
					ld     = out_free;
					o_kind = srsw_pkg::K_CORRUPT;
				end else if (outside) begin
					ld     = out_free;
					o_kind = srsw_pkg::K_OUTSIDE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ack_slot;
				end
			end
			S_ACK_RD: begin
				ram_we    = 1'b1;
				ram_waddr = ack_slot_q;
				ram_wdata = '{acked: 1'b1, sent: rd.sent, start: rd.start, len: rd.len};
			end
			S_SLIDE: begin
				ram_re = (base_seq_q != next_seq_q);
			end
			S_ACK_OUT: begin
				ld     = out_free;
				o_kind = srsw_pkg::K_ACK_OK;
				o_seq  = ack_q[30:0];
				o_off  = a_off_q;
				o_len  = a_len_q;
				o_slot = ack_slot_q;
				o_last = !ack_cmp;
			end
			S_ACK_CMP: begin
				ld     = out_free;
				o_kind = srsw_pkg::K_COMPLETE;
				o_seq  = next_seq_q;
				o_off  = next_off_q;
			end
			S_TICK: begin
				if (tick_more) begin
					ram_re    = 1'b1;
					ram_raddr = scan_slot_q;
				end else begin
					ld = out_free;
					if (pend_v_q) begin
						o_kind = srsw_pkg::K_RESEND;
						o_seq  = pend_seq_q;
						o_off  = pend_off_q;
						o_len  = pend_len_q;
						o_slot = pend_slot_q;
					end
				end
			end
			S_TICK_RD: begin
				o_kind = srsw_pkg::K_RESEND;
				o_seq  = pend_seq_q;
				o_off  = pend_off_q;
				o_len  = pend_len_q;
				o_slot = pend_slot_q;
				o_last = 1'b0;
				if (due && (!pend_v_q || out_free)) begin
					ld        = pend_v_q;
					ram_we    = 1'b1;
					ram_waddr = scan_slot_q;
					ram_wdata = '{acked: 1'b0, sent: now_q, start: rd.start, len: rd.len};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			window_limit_q <= srsw_pkg::WINDOW_LIMIT_RST;
			base_seq_q     <= '0;
			next_seq_q     <= '0;
			next_off_q     <= '0;
			end_seen_q     <= 1'b0;
			base_slot_q    <= '0;
			next_slot_q    <= '0;
			ov_q           <= 1'b0;
			pend_v_q       <= 1'b0;
			n_q            <= '0;
			i_q            <= '0;
		end else begin
			if (cfg_req && (cfg.index == srsw_pkg::REG_WINDOW_LIMIT)) begin
				window_limit_q <= cfg.data[5:0];
			end
			if (ld) begin
				ov_q <= 1'b1;
			end else if (res_out.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_req) begin
						i_q      <= '0;
						n_q      <= '0;
						pend_v_q <= 1'b0;
						case (req_in.cmd)
							srsw_pkg::CMD_SEG:  st_q <= S_SEG;
							srsw_pkg::CMD_ACK:  st_q <= S_CRC;
							srsw_pkg::CMD_TICK: st_q <= S_TICK;
							default:            st_q <= S_IDLE;
						endcase
					end
				end
				S_SEG: begin
					if (out_free) begin
						st_q <= S_IDLE;
						if (!(end_seen_q || full)) begin
							if (len_q == 10'd0) begin
								end_seen_q <= 1'b1;
							end else begin
								next_seq_q  <= next_seq_q + 31'd1;
								next_off_q  <= next_off_q + 32'(len_q);
								next_slot_q <= slot_inc(next_slot_q);
							end
						end
					end
				end
				S_CRC: begin
					if (crc_s.done) begin
						st_q <= S_ACK_CHK;
					end
				end
				S_ACK_CHK: begin
					if (crc_bad_q || outside) begin
						if (out_free) begin
							st_q <= S_IDLE;
						end
					end else begin
						st_q <= S_ACK_RD;
					end
				end
				S_ACK_RD:  st_q <= S_ACK_RTT;
				S_ACK_RTT: begin
					if (rtt_s.done) begin
						st_q <= S_SLIDE;
					end
				end
				S_SLIDE: st_q <= (base_seq_q == next_seq_q) ? S_ACK_OUT : S_SLIDE_RD;
				S_SLIDE_RD: begin
					if (rd.acked) begin
						base_seq_q  <= base_seq_q + 31'd1;
						base_slot_q <= slot_inc(base_slot_q);
						st_q        <= S_SLIDE;
					end else begin
						st_q <= S_ACK_OUT;
					end
				end
				S_ACK_OUT: begin
					if (out_free) begin
						st_q <= ack_cmp ? S_ACK_CMP : S_IDLE;
					end
				end
				S_ACK_CMP: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (tick_more) begin
						st_q <= S_TICK_RD;
					end else if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				S_TICK_RD: begin
					if (!due) begin
						i_q  <= i_q + CNT_W'(1);
						st_q <= S_TICK;
					end else if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + srsw_pkg::RES_CNT_W'(1);
						i_q      <= i_q + CNT_W'(1);
						st_q     <= S_TICK;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			len_q  <= len_cut;
			ack_q  <= req_in.ack_num;
			acrc_q <= req_in.ack_crc;
			now_q  <= req_in.now_us;
			scan_slot_q <= base_slot_q;
		end
		if (crc_s.done) begin
			crc_bad_q <= (crc_s.crc != acrc_q);
		end
		if (st_q == S_ACK_CHK) begin
			ack_slot_q <= ack_slot;
		end
		if (st_q == S_ACK_RD) begin
			a_off_q <= rd.start;
			a_len_q <= rd.len;
		end
		if (st_q == S_TICK_RD) begin
			if (!due || !pend_v_q || out_free) begin
				scan_slot_q <= scan_nxt;
			end
			if (due && (!pend_v_q || out_free)) begin
				pend_seq_q  <= base_seq_q + 31'(i_q);
				pend_off_q  <= rd.start;
				pend_len_q  <= rd.len;
				pend_slot_q <= scan_slot_q;
			end
		end
		if (ld) begin
			okind_q <= o_kind;
			oseq_q  <= o_seq;
			ooff_q  <= o_off;
			olen_q  <= o_len;
			oslot_q <= o_slot;
			oto_q   <= rtt_s.rto;
			olast_q <= o_last;
		end
	end

	assign res_out.valid        = ov_q;
	assign res_out.kind         = okind_q;
	assign res_out.seq_num      = oseq_q;
	assign res_out.seg_offset   = ooff_q;
	assign res_out.out_length   = olen_q;
	assign res_out.slot         = 5'(oslot_q);
	assign res_out.timeout_us   = oto_q;
	assign res_out.last         = olast_q;

	srsw_ram #(.WIDTH(RW), .DEPTH(WINDOW_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srsw_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_c),
		.stat   (crc_s)
	);

	srsw_rtt u_rtt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rtt_c),
		.stat   (rtt_s)
	);

	a_res_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= srsw_pkg::RES_CNT_W'(srsw_pkg::MAX_RESULTS))
		else $error("resend count above limit");

	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding <= 31'(WINDOW_DEPTH))
		else $error("window holds more than the slot RAM");

	a_rtt_done: assert property (@(posedge clk) disable iff (!arst_n)
		rtt_s.done |-> st_q == S_ACK_RTT)
		else $error("RTT update finished outside ack handling");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_req && (req_in.cmd != srsw_pkg::CMD_UNUSED) |=> !req_in.ready)
		else $error("request taken while another is in progress");

	a_no_ld_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !res_out.ready |=> ov_q && $stable(okind_q))
		else $error("waiting result overwritten");
endmodule
